// ===== src/pstb_pkg.sv =====
// Shared constants and types for the periodic timer bank.
// Used by pstb_slot and periodic_software_timer_bank_unit.
`default_nettype none

package pstb_pkg;

  localparam int NUM_TIMERS = 16;

  localparam int MODE_W   = 3;
  localparam int IDX_W    = 4;
  localparam int PERIOD_W = 16;
  localparam int COUNT_W  = 17;
  localparam int MASK_W   = 16;
  localparam int CLOCK_W  = 32;

  localparam logic [MODE_W-1:0] MODE_TICK1  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TICK10 = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ENABLE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_STOP   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CONT   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd5;

  localparam int LONG_TICK_MS = 10;

  // Decoded command, already gated by the pipeline advance.
  typedef struct packed {
    logic                tick;
    logic                long_tick;
    logic                enable;
    logic                stop;
    logic                cont;
    logic [PERIOD_W-1:0] period;
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/periodic_software_timer_bank_unit.sv =====
// Periodic timer bank: input register, parallel timer slots, result register.
// An accepted item passes through the input register, then the result register.
// One item per cycle while the result register is not stalled; every slot updates in the same cycle.
// The result register holds while stalled; the input side keeps accepting
// as long as the result register can drain. Synchronous reset clears all
// periods, countdowns, run flags and the millisecond clock.
`default_nettype none

module periodic_software_timer_bank_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [pstb_pkg::MODE_W-1:0]   mode,
  input  wire logic [pstb_pkg::IDX_W-1:0]    timer_index,
  input  wire logic [pstb_pkg::PERIOD_W-1:0] period_ms,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [pstb_pkg::MASK_W-1:0]        fired_mask,
  output logic                               is_running,
  output logic [pstb_pkg::CLOCK_W-1:0]       elapsed_ms
);

  // input register
  logic                          s1_valid;
  logic [pstb_pkg::MODE_W-1:0]   s1_mode;
  logic [pstb_pkg::IDX_W-1:0]    s1_idx;
  logic [pstb_pkg::PERIOD_W-1:0] s1_period;

  logic [pstb_pkg::CLOCK_W-1:0]    ms_clock;
  logic [pstb_pkg::CLOCK_W-1:0]    ms_clock_next;
  logic                            advance;
  logic                            in_take;
  pstb_pkg::cmd_t                  cmd;
  logic [pstb_pkg::NUM_TIMERS-1:0] sel;
  logic [pstb_pkg::NUM_TIMERS-1:0] fired_vec;
  logic [pstb_pkg::NUM_TIMERS-1:0] running_vec;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    cmd           = '0;
    cmd.period    = s1_period;
    ms_clock_next = ms_clock;
    if (advance) begin
      case (s1_mode)
        pstb_pkg::MODE_TICK1: begin
          cmd.tick      = 1'b1;
          ms_clock_next = ms_clock + pstb_pkg::CLOCK_W'(1);
        end
        pstb_pkg::MODE_TICK10: begin
          cmd.tick      = 1'b1;
          cmd.long_tick = 1'b1;
          ms_clock_next = ms_clock + pstb_pkg::CLOCK_W'(pstb_pkg::LONG_TICK_MS);
        end
        pstb_pkg::MODE_ENABLE: cmd.enable = 1'b1;
        pstb_pkg::MODE_STOP:   cmd.stop   = 1'b1;
        pstb_pkg::MODE_CONT:   cmd.cont   = 1'b1;
        pstb_pkg::MODE_QUERY:  cmd.tick   = 1'b0;
        default:               cmd.tick   = 1'b0;
      endcase
    end
  end

  // every 4-bit index selects exactly one of the 16 slots
  always_comb begin
    for (int n = 0; n < pstb_pkg::NUM_TIMERS; n++) begin
      sel[n] = (32'(s1_idx) == n);
    end
  end

  for (genvar g = 0; g < pstb_pkg::NUM_TIMERS; g++) begin : g_slot
    pstb_slot u_slot (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .sel     (sel[g]),
      .fired   (fired_vec[g]),
      .running (running_vec[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
      ms_clock <= '0;
    end else begin
      ms_clock <= ms_clock_next;
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode   <= mode;
      s1_idx    <= timer_index;
      s1_period <= period_ms;
    end
    if (advance) begin
      // the mask has one bit per timer
      fired_mask <= pstb_pkg::MASK_W'(fired_vec);
      is_running <= |(sel & running_vec);
      elapsed_ms <= ms_clock_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/pstb_slot.sv =====
// One timer of the bank: period, signed countdown and run flag.
// Depends on pstb_pkg for widths and the command struct.
`default_nettype none

module pstb_slot (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire pstb_pkg::cmd_t cmd,
  input  wire logic          sel,
  output logic               fired,
  output logic               running
);

  logic [pstb_pkg::PERIOD_W-1:0]       period;
  logic signed [pstb_pkg::COUNT_W-1:0] countdown;
  logic                                run;

  logic signed [pstb_pkg::COUNT_W-1:0] step;
  logic signed [pstb_pkg::COUNT_W-1:0] dec;
  logic signed [pstb_pkg::COUNT_W-1:0] reload;
  logic signed [pstb_pkg::COUNT_W-1:0] load_val;
  logic signed [pstb_pkg::COUNT_W-1:0] countdown_next;
  logic [pstb_pkg::PERIOD_W-1:0]       period_next;
  logic                                run_next;

  always_comb begin
    step     = cmd.long_tick ? pstb_pkg::COUNT_W'(pstb_pkg::LONG_TICK_MS)
                             : pstb_pkg::COUNT_W'(1);
    dec      = countdown - step;
    reload   = $signed({1'b0, period}) - pstb_pkg::COUNT_W'(1);
    load_val = $signed({1'b0, cmd.period}) - pstb_pkg::COUNT_W'(1);
    fired    = cmd.tick && run && dec[pstb_pkg::COUNT_W-1];

    countdown_next = countdown;
    period_next    = period;
    run_next       = run;
    if (cmd.tick && run) begin
      // drop any remainder on expiry
      countdown_next = fired ? reload : dec;
    end
    if (sel) begin
      if (cmd.enable) begin
        period_next    = cmd.period;
        countdown_next = load_val;
        run_next       = 1'b1;
      end
      if (cmd.stop) begin
        run_next = 1'b0;
      end
      if (cmd.cont) begin
        run_next = 1'b1;
      end
    end
    running = run_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period    <= '0;
      countdown <= '0;
      run       <= 1'b0;
    end else begin
      period    <= period_next;
      countdown <= countdown_next;
      run       <= run_next;
    end
  end

endmodule

`default_nettype wire
